// File: hdl/fnq_pkg.sv
// fnq_pkg: shared constants and helper functions for the frequency to note quantizer.
// No dependencies.
package fnq_pkg;

  localparam int unsigned FreqW  = 24;
  localparam int unsigned RefW   = 18;
  localparam int unsigned CentsW = 10;
  localparam int unsigned TW     = 38;

  localparam logic signed [TW-1:0] C0_OFFSET = 38'sd3735552000;  // 57000 * 65536
  localparam logic signed [TW-1:0] HALF_UNIT = 38'sd32768000;    // 1000 * 65536 / 2
  localparam logic signed [TW-1:0] CENT_HALF = 38'sd32768;
  localparam logic [13:0]          TENTHS_PER_OCT = 14'd12000;
  localparam logic [19:0]          RECIP_1000 = 20'd536871;      // ceil(2^29 / 1000)
  localparam logic [9:0]           RECIP_12 = 10'd683;           // ceil(2^13 / 12)
  localparam logic [9:0]           UNIT_TENTHS = 10'd1000;
  localparam logic [4:0]           OCT_MAX = 5'd11;
  localparam logic [4:0]           SHIFT_BASE = 5'd21;

  function automatic logic [4:0] msb_pos(input logic [FreqW-1:0] x);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < FreqW; i++) begin
      if (x[i]) p = 5'(i);
    end
    return p;
  endfunction

  // One squaring step of the log2 mantissa (Q1.30); returns {fraction bit, new mantissa}.
  function automatic logic [31:0] log_step(input logic [30:0] m);
    logic [61:0] sq;
    logic [31:0] s;
    sq = 62'(m) * 62'(m);
    s  = sq[61:30];
    if (s[31]) return {1'b1, s[31:1]};
    return {1'b0, s[30:0]};
  endfunction

  function automatic logic [16:0] semitone(input logic [3:0] r);
    case (r)
      4'd0:    return 17'd65536;
      4'd1:    return 17'd69433;
      4'd2:    return 17'd73562;
      4'd3:    return 17'd77936;
      4'd4:    return 17'd82570;
      4'd5:    return 17'd87480;
      4'd6:    return 17'd92682;
      4'd7:    return 17'd98193;
      4'd8:    return 17'd104032;
      4'd9:    return 17'd110218;
      4'd10:   return 17'd116772;
      4'd11:   return 17'd123715;
      default: return 17'd65536;
    endcase
  endfunction

endpackage

// File: hdl/fnq_if.sv
// fnq_in_if / fnq_out_if: valid/ready stream channels of the quantizer.
// Depends on fnq_pkg.
interface fnq_in_if import fnq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [FreqW-1:0] measured_frequency;
  modport source (output valid, output measured_frequency, input ready);
  modport sink   (input valid, input measured_frequency, output ready);
endinterface

interface fnq_out_if import fnq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [3:0]               note_index;
  logic [3:0]               octave_number;
  logic [FreqW-1:0]         note_frequency;
  logic signed [CentsW-1:0] cents_tenths;
  logic                     in_range;
  modport source (output valid, output note_index, output octave_number,
                  output note_frequency, output cents_tenths, output in_range, input ready);
  modport sink   (input valid, input note_index, input octave_number,
                  input note_frequency, input cents_tenths, input in_range, output ready);
endinterface

// File: hdl/frequency_to_note_quantizer_core.sv
// frequency_to_note_quantizer_core: pipelined frequency to equal-temperament note quantizer.
// Depends on fnq_pkg and fnq_if.
//
//   channel   dir  handshake          payload
//   in_ch     in   valid/ready        measured_frequency
//   out_ch    out  valid/ready        note_index, octave_number, note_frequency,
//                                     cents_tenths, in_range
//   cfg       in   cfg_write          cfg_data -> reference_pitch
//
// One transaction per cycle while the output is not stalled; 17 log2 stages (setup plus
// 16 squarings), then 6 math stages.
// Synchronous reset clears valid bits and loads reference_pitch with 440 Hz.
// A stalled output register holds the whole pipeline; in_ch.ready is high whenever
// the output register is empty or being read.
module frequency_to_note_quantizer_core import fnq_pkg::*; #(
  parameter int FRACTION_BITS = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  logic [RefW-1:0] cfg_data,
  fnq_in_if.sink          in_ch,
  fnq_out_if.source       out_ch
);

  localparam logic [RefW-1:0] REF_RESET = RefW'(32'd440 << FRACTION_BITS);
  localparam int LOG_STAGES = 16;

  logic [RefW-1:0] reference_pitch;
  logic            adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_pitch <= REF_RESET;
    end else if (cfg_write) begin
      reference_pitch <= cfg_data;
    end
  end

  logic v22;
  assign adv = !v22 || out_ch.ready;
  assign in_ch.ready = adv;

  // log2 pipeline
  logic [30:0]     mfa [0:LOG_STAGES];
  logic [30:0]     mra [0:LOG_STAGES];
  logic [15:0]     ffa [0:LOG_STAGES];
  logic [15:0]     fra [0:LOG_STAGES];
  logic [4:0]      efa [0:LOG_STAGES];
  logic [4:0]      era [0:LOG_STAGES];
  logic [RefW-1:0] refa [0:LOG_STAGES];
  logic            zra [0:LOG_STAGES];
  logic            lv  [0:LOG_STAGES];

  logic [RefW-1:0]  ref_eff;
  logic [FreqW-1:0] f_eff;
  logic [4:0]       ef_in, er_in;

  always_comb begin
    ref_eff = (reference_pitch == '0) ? RefW'(1) : reference_pitch;
    f_eff   = (in_ch.measured_frequency == '0) ? FreqW'(1) : in_ch.measured_frequency;
    ef_in   = msb_pos(f_eff);
    er_in   = msb_pos(FreqW'(ref_eff));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lv[0] <= 1'b0;
    end else if (adv) begin
      lv[0] <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mfa[0]  <= 31'(f_eff) << (5'd30 - ef_in);
      mra[0]  <= 31'(ref_eff) << (5'd30 - er_in);
      efa[0]  <= ef_in;
      era[0]  <= er_in;
      ffa[0]  <= '0;
      fra[0]  <= '0;
      refa[0] <= ref_eff;
      zra[0]  <= (in_ch.measured_frequency == '0);
    end
  end

  for (genvar j = 1; j <= LOG_STAGES; j++) begin : g_log
    logic [31:0] sf, sr;
    assign sf = log_step(mfa[j-1]);
    assign sr = log_step(mra[j-1]);

    always_ff @(posedge clk) begin
      if (rst) begin
        lv[j] <= 1'b0;
      end else if (adv) begin
        lv[j] <= lv[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        mfa[j]  <= sf[30:0];
        mra[j]  <= sr[30:0];
        ffa[j]  <= {ffa[j-1][14:0], sf[31]};
        fra[j]  <= {fra[j-1][14:0], sr[31]};
        efa[j]  <= efa[j-1];
        era[j]  <= era[j-1];
        refa[j] <= refa[j-1];
        zra[j]  <= zra[j-1];
      end
    end
  end

  // stage 17: scale log difference to tenths of a cent
  logic signed [21:0]   diff;
  logic signed [TW-1:0] prod17;
  logic [RefW-1:0]      ref17;
  logic                 zr17, v17;

  assign diff = $signed({1'b0, efa[LOG_STAGES], ffa[LOG_STAGES]})
              - $signed({1'b0, era[LOG_STAGES], fra[LOG_STAGES]});

  // stage 18: offset to C0, round to semitone units
  logic signed [TW-1:0] t18, t18_next, x18;
  logic [18:0]          y18;
  logic                 ok18, v18;
  logic [RefW-1:0]      ref18;

  assign t18_next = prod17 + C0_OFFSET;
  assign x18      = t18_next + HALF_UNIT;

  // stage 19: semitone count
  logic [38:0]          ny;
  logic [8:0]           n19;
  logic signed [TW-1:0] t19;
  logic                 ok19, v19;
  logic [RefW-1:0]      ref19;

  assign ny = 39'(y18) * 39'(RECIP_1000);

  // stage 20: cents residue, divide by 12
  logic signed [TW-1:0] nu, cp20;
  logic [8:0]           k19;
  logic [18:0]          nq_p, kq_p;
  logic [8:0]           n20, k20;
  logic [4:0]           nq20, kq20;
  logic                 ok20, v20;
  logic [RefW-1:0]      ref20;

  assign nu   = (TW'(n19) * TW'(UNIT_TENTHS)) <<< 16;
  assign k19  = n19 + 9'd3;
  assign nq_p = 19'(n19) * 19'(RECIP_12);
  assign kq_p = 19'(k19) * 19'(RECIP_12);

  // stage 21: note, octave, scaled reference
  logic [3:0]  ni21, oc21, r20;
  logic [34:0] p21;
  logic [4:0]  kq21;
  logic [CentsW-1:0] c21;
  logic        ok21, v21;

  assign r20 = 4'(k20 - 9'(kq20) * 9'd12);

  // stage 22: output register
  logic [43:0] fv;
  logic [4:0]  sh;
  logic [FreqW-1:0] nf_next;

  always_comb begin
    sh = '0;
    if (kq21 < SHIFT_BASE) begin
      sh = SHIFT_BASE - kq21;
      fv = (44'(p21) + (44'd1 << (sh - 5'd1))) >> sh;
    end else begin
      sh = kq21 - SHIFT_BASE;
      fv = 44'(p21) << sh;
    end
    nf_next = (fv > 44'hFFFFFF) ? FreqW'(24'hFFFFFF) : fv[FreqW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v17 <= 1'b0;
      v18 <= 1'b0;
      v19 <= 1'b0;
      v20 <= 1'b0;
      v21 <= 1'b0;
      v22 <= 1'b0;
    end else if (adv) begin
      v17 <= lv[LOG_STAGES];
      v18 <= v17;
      v19 <= v18;
      v20 <= v19;
      v21 <= v20;
      v22 <= v21;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod17 <= TW'(diff) * $signed({24'd0, TENTHS_PER_OCT});
      ref17  <= refa[LOG_STAGES];
      zr17   <= zra[LOG_STAGES];

      t18   <= t18_next;
      y18   <= x18[34:16];
      ok18  <= !zr17 && !x18[TW-1] && (x18 != '0);
      ref18 <= ref17;

      n19   <= ny[37:29];
      t19   <= t18;
      ok19  <= ok18;
      ref19 <= ref18;

      cp20  <= t19 - nu + CENT_HALF;
      n20   <= n19;
      k20   <= k19;
      nq20  <= nq_p[17:13];
      kq20  <= kq_p[17:13];
      ok20  <= ok19;
      ref20 <= ref19;

      ni21 <= 4'(n20 - 9'(nq20) * 9'd12);
      oc21 <= (nq20 > OCT_MAX) ? 4'(OCT_MAX) : nq20[3:0];
      p21  <= 35'(ref20) * 35'(semitone(r20));
      kq21 <= kq20;
      c21  <= cp20[25:16];
      ok21 <= ok20;

      out_ch.note_index     <= ok21 ? ni21 : '0;
      out_ch.octave_number  <= ok21 ? oc21 : '0;
      out_ch.note_frequency <= ok21 ? nf_next : '0;
      out_ch.cents_tenths   <= ok21 ? $signed(c21) : '0;
      out_ch.in_range       <= ok21;
    end
  end

  assign out_ch.valid = v22;

  a_ready_follows_output: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready == (!out_ch.valid || out_ch.ready))
    else $error("input ready does not follow output register state");

  a_note_in_octave: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.note_index < 4'd12 && out_ch.octave_number < 4'd12))
    else $error("note or octave out of range");

  a_cents_bounded: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.in_range) |->
      (out_ch.cents_tenths >= -10'sd500 && out_ch.cents_tenths <= 10'sd500))
    else $error("cents deviation out of range");

  a_out_of_range_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.in_range) |->
      (out_ch.note_frequency == '0 && out_ch.note_index == '0))
    else $error("out of range result not cleared");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    ($past(out_ch.valid) && !$past(out_ch.ready)) |-> $stable(out_ch.note_frequency))
    else $error("stalled result changed");

endmodule

// File: tb/tb_frequency_to_note_quantizer_core.sv
// tb_frequency_to_note_quantizer_core: drives random and directed frequencies through the
// quantizer under several A4 reference settings and checks every result against a predictor.
// Depends on fnq_pkg, fnq_if and frequency_to_note_quantizer_core.
module tb_frequency_to_note_quantizer_core import fnq_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [3:0]               note_index;
    logic [3:0]               octave_number;
    logic [FreqW-1:0]         note_frequency;
    logic signed [CentsW-1:0] cents_tenths;
    logic                     in_range;
  } note_result_t;

  class note_scoreboard;
    note_result_t pending[$];
    logic [RefW-1:0] a4_pitch;
    int mismatches;
    int checked;

    function new();
      a4_pitch = 18'(440 << 8);
      mismatches = 0;
      checked = 0;
    endfunction

    function longint log2_fix(int unsigned x);
      int unsigned e;
      longint unsigned m;
      int unsigned fr;
      e = 0;
      fr = 0;
      if (x == 0) x = 1;
      while (e < 31 && (x >> (e + 1)) != 0) e++;
      m = longint'(x) << (30 - e);
      for (int i = 0; i < 16; i++) begin
        m = (m * m) >> 30;
        fr = fr << 1;
        if (m >= 64'h8000_0000) begin
          fr = fr | 1;
          m = m >> 1;
        end
      end
      return longint'((e << 16) | fr);
    endfunction

    function logic [FreqW-1:0] pitch_of(longint unsigned a4, longint n);
      longint k, s;
      longint unsigned p, v;
      longint unsigned steps[12] = '{65536, 69433, 73562, 77936, 82570, 87480,
                                     92682, 98193, 104032, 110218, 116772, 123715};
      k = n + 3;
      s = 21 - k / 12;
      p = a4 * steps[k % 12];
      if (s > 0) v = (p + (64'd1 << (s - 1))) >> s;
      else begin
        if (-s > 20) return '1;
        v = p << (-s);
      end
      return (v > 64'hFFFFFF) ? '1 : FreqW'(v);
    endfunction

    function void note_input(logic [FreqW-1:0] f);
      note_result_t r;
      longint a4, t, n;
      r = '0;
      a4 = (a4_pitch == 0) ? 1 : longint'(a4_pitch);
      if (f != 0) begin
        t = (log2_fix(f) - log2_fix(int'(a4))) * 12000 + 64'd57000 * 65536;
        if (t > -64'sd32768000) begin
          n = (t + 32768000) / 65536000;
          r.note_index = 4'(n % 12);
          r.octave_number = (n / 12 > 11) ? 4'd11 : 4'(n / 12);
          r.note_frequency = pitch_of(a4, n);
          r.cents_tenths = CentsW'((t - n * 65536000 + 32768) >>> 16);
          r.in_range = 1'b1;
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(note_result_t got);
      note_result_t want;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_write = 0;
  logic [RefW-1:0] cfg_data = '0;
  fnq_in_if in_ch();
  fnq_out_if out_ch();
  note_scoreboard sb = new();
  int idle_cycles = 0;
  bit hold_pending = 1;

  always #10 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.measured_frequency = '0;
    out_ch.ready = 0;
  end

  frequency_to_note_quantizer_core dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 3000) begin
      $display("tb_frequency_to_note_quantizer_core: done, errors");
      $finish;
    end
  end

  bit in_calm = 0;
  task automatic send_freq(logic [FreqW-1:0] f);
    int g;
    if ($urandom_range(0, 39) == 0) in_calm = ~in_calm;
    g = in_calm ? 0 : $urandom_range(0, 13);
    if (g > 0) begin
      in_ch.valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.measured_frequency <= f;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(f);
  endtask

  task automatic set_a4(logic [RefW-1:0] v);
    in_ch.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_write <= 1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 0;
    sb.a4_pitch = v;
  endtask

  function automatic logic [FreqW-1:0] rand_freq();
    int e;
    case ($urandom_range(0, 9))
      0: return FreqW'($urandom);
      1: return (FreqW'(1) << $urandom_range(0, 23)) + FreqW'($urandom_range(0, 2))
                - FreqW'(1);
      default: begin
        e = $urandom_range(0, 23);
        return (FreqW'(1) << e) | (FreqW'($urandom) & ((FreqW'(1) << e) - FreqW'(1)));
      end
    endcase
  endfunction

  // receiver with one long hold-off to back up the pipeline
  bit out_calm = 0;
  initial begin
    int g;
    note_result_t got;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 39) == 0) out_calm = ~out_calm;
      g = out_calm ? 0 : $urandom_range(0, 13);
      if (hold_pending && sb.checked >= 300) begin
        hold_pending = 0;
        g = 400;
      end
      if (g > 0) begin
        out_ch.ready <= 0;
        repeat (g) @(posedge clk);
      end
      out_ch.ready <= 1;
      do @(posedge clk); while (!out_ch.valid);
      got.note_index = out_ch.note_index;
      got.octave_number = out_ch.octave_number;
      got.note_frequency = out_ch.note_frequency;
      got.cents_tenths = out_ch.cents_tenths;
      got.in_range = out_ch.in_range;
      sb.check_result(got);
    end
  end

  initial begin
    logic [RefW-1:0] a4_list[7];
    logic [FreqW-1:0] directed[$];
    a4_list = '{18'd112640, 18'd76800, 18'd153600, 18'd0, 18'h3FFFF, 18'd1, 18'd100000};
    a4_list[6] = 18'($urandom_range(76800, 153600));
    directed = '{24'd0, 24'd1, 24'hFFFFFF, 24'h800000, 24'hFFFF00, 24'd4000, 24'd4066,
                 24'd4067, 24'd4068, 24'd4186, 24'd112640, 24'd115940, 24'd115942,
                 24'd225280, 24'h555555, 24'hAAAAAA, 24'd2, 24'd3};
    repeat (12) @(posedge clk);
    rst <= 0;
    foreach (a4_list[p]) begin
      if (p > 0) set_a4(a4_list[p]);
      foreach (directed[i]) send_freq(directed[i]);
      repeat (180) send_freq(rand_freq());
    end
    in_ch.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("tb_frequency_to_note_quantizer_core: done, clean");
    else
      $display("tb_frequency_to_note_quantizer_core: done, errors");
    $finish;
  end
endmodule
